// ----- hw/rtl/fqd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fqd_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned HandleW = 32;
  localparam int unsigned CountW  = 5;

  localparam logic [KindW-1:0] KIND_ENQ = 2'd0;
  localparam logic [KindW-1:0] KIND_DEQ = 2'd1;
  localparam logic [KindW-1:0] KIND_DEL = 2'd2;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY     = 2'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd3;

  // Operation strobes broadcast to every cell of the row.
  typedef struct packed {
    logic enq;
    logic deq;
    logic del;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fqd_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fqd_cell #(
  parameter int unsigned W = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fqd_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [W-1:0]       key_i,
  input  wire logic               prev_valid_i,
  input  wire logic               next_valid_i,
  input  wire logic [W-1:0]       next_data_i,
  input  wire logic               seen_i,
  output logic                    valid_o,
  output logic [W-1:0]            data_o,
  output logic                    seen_o
);

  logic         valid_q, valid_d;
  logic [W-1:0] data_q, data_d;
  logic         match;
  logic         shift;
  logic         load;

  assign match  = valid_q && (data_q == key_i);
  // A match here or in any older cell means this cell takes its younger neighbor.
  assign seen_o = seen_i | match;
  assign shift  = ctrl_i.deq | (ctrl_i.del & seen_o);
  // The first free cell is the tail slot for an enqueue.
  assign load   = ctrl_i.enq & ~valid_q & prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (shift) begin
      valid_d = next_valid_i;
      data_d  = next_data_i;
    end else if (load) begin
      valid_d = 1'b1;
      data_d  = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/fifo_queue_with_delete.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Queue of handles held in a row of DEPTH cells, head in cell 0. Every
// operation (enqueue, dequeue, delete of the oldest equal handle) is applied
// to the row: all cells compare against the handle at once, the match flag
// ripples from the head toward the tail, and each cell at or behind the
// removed entry takes its younger neighbor in the same edge. The result is
// registered and appears in the cycle after the item is accepted; a new item is
// taken in every cycle in which the result register is empty or being read.

module fifo_queue_with_delete #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned HANDLE_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [fqd_pkg::KindW-1:0]     kind_i,
  input  wire logic [fqd_pkg::HandleW-1:0]   handle_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [fqd_pkg::StatusW-1:0]        status_o,
  output logic [fqd_pkg::HandleW-1:0]        out_handle_o,
  output logic [fqd_pkg::CountW-1:0]         entry_count_o,
  output logic                               is_empty_o
);

  localparam int unsigned StoreW = (HANDLE_WIDTH < fqd_pkg::HandleW) ? HANDLE_WIDTH
                                                                     : fqd_pkg::HandleW;
  localparam int unsigned CntW   = $clog2(DEPTH + 1);

  fqd_pkg::cell_ctrl_t ctrl;
  logic [StoreW-1:0]   key;
  logic [DEPTH-1:0]    cell_valid;
  logic [StoreW-1:0]   cell_data [DEPTH];
  logic [DEPTH:0]      seen;
  logic                in_fire;
  logic                full;
  logic                empty;

  logic [CntW-1:0]                 count_q, count_d;
  logic                            out_valid_q;
  logic [fqd_pkg::StatusW-1:0]     status_q, status_d;
  logic [fqd_pkg::HandleW-1:0]     handle_q, handle_d;
  logic [31:0]                     count_wide;

  assign key     = handle_i[StoreW-1:0];
  assign seen[0] = 1'b0;
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              prev_v;
    logic              next_v;
    logic [StoreW-1:0] next_d;
    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_v = 1'b0;
      assign next_d = '0;
    end else begin : g_inner
      assign next_v = cell_valid[i+1];
      assign next_d = cell_data[i+1];
    end

    fqd_cell #(
      .W(StoreW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .key_i       (key),
      .prev_valid_i(prev_v),
      .next_valid_i(next_v),
      .next_data_i (next_d),
      .seen_i      (seen[i]),
      .valid_o     (cell_valid[i]),
      .data_o      (cell_data[i]),
      .seen_o      (seen[i+1])
    );
  end

  always_comb begin
    ctrl     = '0;
    status_d = fqd_pkg::ST_OK;
    handle_d = '0;
    count_d  = count_q;
    if (in_fire) begin
      unique case (kind_i)
        fqd_pkg::KIND_ENQ: begin
          if (full) begin
            status_d = fqd_pkg::ST_FULL;
          end else begin
            ctrl.enq = 1'b1;
            count_d  = count_q + CntW'(1);
          end
        end
        fqd_pkg::KIND_DEQ: begin
          if (empty) begin
            status_d = fqd_pkg::ST_EMPTY;
          end else begin
            ctrl.deq = 1'b1;
            handle_d = fqd_pkg::HandleW'(cell_data[0]);
            count_d  = count_q - CntW'(1);
          end
        end
        fqd_pkg::KIND_DEL: begin
          if (empty) begin
            status_d = fqd_pkg::ST_EMPTY;
          end else if (!seen[DEPTH]) begin
            status_d = fqd_pkg::ST_NOT_FOUND;
          end else begin
            ctrl.del = 1'b1;
            count_d  = count_q - CntW'(1);
          end
        end
        default: begin
          // Unused operation code: nothing changes.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      handle_q <= handle_d;
    end
  end

  // The result shows the count after the operation, which is count_q once loaded.
  logic [CntW-1:0] count_res_q;
  logic            empty_res_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      count_res_q <= count_d;
      empty_res_q <= (count_d == '0);
    end
  end

  assign count_wide    = 32'(count_res_q);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_handle_o  = handle_q;
  assign entry_count_o = count_wide[fqd_pkg::CountW-1:0];
  assign is_empty_o    = empty_res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/fqd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fqd_checker #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned HANDLE_WIDTH = 32
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic [fqd_pkg::KindW-1:0]     kind_i,
  input wire logic [fqd_pkg::HandleW-1:0]   handle_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [fqd_pkg::StatusW-1:0]   status_o,
  input wire logic [fqd_pkg::HandleW-1:0]   out_handle_o,
  input wire logic [fqd_pkg::CountW-1:0]    entry_count_o,
  input wire logic                          is_empty_o
);

  logic small_depth;
  assign small_depth = (DEPTH < 32) && (HANDLE_WIDTH > 0);

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(out_handle_o) && $stable(entry_count_o))
    else $error("result changed while stalled");

  a_ready_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no pending result");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && small_depth |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with count");

  a_handle_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_handle_o != '0) |-> status_o == fqd_pkg::ST_OK)
    else $error("handle returned on a failed operation");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == fqd_pkg::ST_FULL) |-> !is_empty_o)
    else $error("full status with empty queue");

endmodule

bind fifo_queue_with_delete fqd_checker #(
  .DEPTH       (DEPTH),
  .HANDLE_WIDTH(HANDLE_WIDTH)
) u_fqd_checker (.*);

`default_nettype wire
